// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Operation and status codes, and the job record that passes from the front
// end to the back end.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int MagW = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // job handed from front to back: signed-magnitude numerator and denominator
  typedef struct packed {
    logic            num_neg;
    logic [MagW-1:0] num_mag;
    logic            den_neg;
    logic [MagW-1:0] den_mag;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_CHECK,
    BK_OUT
  } bk_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL1,
    FR_MUL2,
    FR_MUL3,
    FR_SUM,
    FR_PUSH
  } fr_state_t;

endpackage

// ===== hw/rtl/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front: operand intake and cross products
// Converts operands to sign-magnitude, forms the cross products one multiply
// per cycle and pushes a job into the queue.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  logic [1:0]           operation,
  input  logic signed [31:0]   a_numerator,
  input  logic signed [31:0]   a_denominator,
  input  logic signed [31:0]   b_numerator,
  input  logic signed [31:0]   b_denominator,
  output logic                 job_valid,
  input  logic                 job_ready,
  output rau_pkg::job_t        job
);

  localparam int W = VALUE_WIDTH;
  localparam int MW = rau_pkg::MagW;

  rau_pkg::fr_state_t state, state_next;
  logic [1:0]   op;
  logic         an_s, ad_s, bn_s, bd_s;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic [MW-1:0] p1, p2, p3;
  logic          p1_s, p2_s, p3_s;
  rau_pkg::job_t job_r;

  function automatic logic [W:0] to_sm(input logic [31:0] raw);
    logic [W-1:0] v;
    logic         s;
    v = raw[W-1:0];
    s = v[W-1];
    to_sm = {s, s ? (~v + 1'b1) : v};
  endfunction

  logic [W-1:0] ma, mb;
  logic         sa, sb;
  logic [MW-1:0] prod;
  logic [W:0]    bn_in;
  logic          bn_flip;

  assign bn_in   = to_sm(b_numerator);
  // subtract flips b's sign only for a nonzero magnitude
  assign bn_flip = (operation == rau_pkg::OP_SUB) && (bn_in[W-1:0] != '0);

  always_comb begin
    ma = an_m; mb = bd_m; sa = an_s; sb = bd_s;
    case (state)
      rau_pkg::FR_MUL1: begin
        if (op == rau_pkg::OP_MUL) begin
          mb = bn_m; sb = bn_s;
        end
      end
      rau_pkg::FR_MUL2: begin
        ma = ad_m; sa = ad_s; mb = bd_m; sb = bd_s;
        if (op == rau_pkg::OP_DIV) begin
          mb = bn_m; sb = bn_s;
        end
      end
      rau_pkg::FR_MUL3: begin
        ma = ad_m; sa = ad_s; mb = bn_m; sb = bn_s;
      end
      default: ;
    endcase
  end

  assign prod = MW'(ma) * MW'(mb);

  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::FR_IDLE: if (valid) state_next = rau_pkg::FR_MUL1;
      rau_pkg::FR_MUL1: state_next = rau_pkg::FR_MUL2;
      rau_pkg::FR_MUL2: state_next = (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) ?
                                     rau_pkg::FR_MUL3 : rau_pkg::FR_SUM;
      rau_pkg::FR_MUL3: state_next = rau_pkg::FR_SUM;
      rau_pkg::FR_SUM:  state_next = rau_pkg::FR_PUSH;
      rau_pkg::FR_PUSH: if (job_ready) state_next = rau_pkg::FR_IDLE;
      default:          state_next = rau_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::FR_IDLE: begin
        if (valid) begin
          op <= operation;
          {an_s, an_m} <= to_sm(a_numerator);
          {ad_s, ad_m} <= to_sm(a_denominator);
          {bn_s, bn_m} <= {bn_in[W] ^ bn_flip, bn_in[W-1:0]};
          {bd_s, bd_m} <= to_sm(b_denominator);
        end
      end
      rau_pkg::FR_MUL1: begin p1 <= prod; p1_s <= (sa != sb) && prod != '0; end
      rau_pkg::FR_MUL2: begin p2 <= prod; p2_s <= (sa != sb) && prod != '0; end
      rau_pkg::FR_MUL3: begin p3 <= prod; p3_s <= (sa != sb) && prod != '0; end
      rau_pkg::FR_SUM: begin
        if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
          job_r.den_mag <= p2;
          job_r.den_neg <= p2_s;
          if (p1_s == p3_s) begin
            job_r.num_mag <= p1 + p3;
            job_r.num_neg <= p1_s && (p1 + p3) != '0;
          end else if (p1 >= p3) begin
            job_r.num_mag <= p1 - p3;
            job_r.num_neg <= p1_s && (p1 - p3) != '0;
          end else begin
            job_r.num_mag <= p3 - p1;
            job_r.num_neg <= p3_s;
          end
        end else begin
          job_r.num_mag <= p1; job_r.num_neg <= p1_s;
          job_r.den_mag <= p2; job_r.den_neg <= p2_s;
        end
      end
      default: ;
    endcase
  end

  assign ready     = (state == rau_pkg::FR_IDLE);
  assign job_valid = (state == rau_pkg::FR_PUSH);
  assign job       = job_r;

endmodule

// ===== hw/rtl/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rau_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output rau_pkg::job_t out_job
);

  rau_pkg::job_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) count <= 2'd2;
  endproperty
  assert property (p_no_overflow) else $error("queue count beyond depth");

  property p_pop_nonempty;
    @(posedge clk) disable iff (rst) (count == 2'd0) |-> !pop;
  endproperty
  assert property (p_pop_nonempty) else $error("pop from empty queue");

  property p_count_step;
    @(posedge clk) disable iff (rst) (push && !pop) |=> (count == $past(count) + 2'd1);
  endproperty
  assert property (p_count_step) else $error("queue count did not advance");

endmodule

// ===== hw/rtl/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back: reduction engine
// Binary gcd one step a cycle, then two restoring divisions one bit a cycle,
// then a range check and output register; a zero part skips to the check.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  rau_pkg::job_t       job,
  output logic                valid,
  input  logic                ready,
  output logic signed [31:0]  result_numerator,
  output logic [30:0]         result_denominator,
  output logic [1:0]          status
);

  localparam int MW = rau_pkg::MagW;
  localparam logic [MW-1:0] Half = MW'(1) << (VALUE_WIDTH - 1);

  rau_pkg::bk_state_t state, state_next;
  logic [MW-1:0] nm, dm, gx, gy, g, q, rem;
  logic [6:0]    shift;
  logic [5:0]    bitc;
  logic          neg;
  logic [MW-1:0] dividend;
  logic [MW:0]   trial;

  assign dividend = (state == rau_pkg::BK_DIVN) ? nm : dm;
  assign trial    = {rem, dividend[bitc]} - {1'b0, g};

  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::BK_IDLE: if (job_valid) state_next = rau_pkg::BK_GCD;
      rau_pkg::BK_GCD: begin
        if (dm == '0) state_next = rau_pkg::BK_CHECK;
        else if (nm == '0) state_next = rau_pkg::BK_CHECK;
        else if (gx == gy) state_next = rau_pkg::BK_DIVN;
      end
      rau_pkg::BK_DIVN:  if (bitc == '0) state_next = rau_pkg::BK_DIVD;
      rau_pkg::BK_DIVD:  if (bitc == '0) state_next = rau_pkg::BK_CHECK;
      rau_pkg::BK_CHECK: state_next = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT:   if (ready) state_next = rau_pkg::BK_IDLE;
      default:           state_next = rau_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::BK_IDLE: begin
        if (job_valid) begin
          nm    <= job.num_mag;
          dm    <= job.den_mag;
          gx    <= job.num_mag;
          gy    <= job.den_mag;
          shift <= '0;
          neg   <= (job.num_mag != '0) && (job.num_neg != job.den_neg);
        end
      end
      rau_pkg::BK_GCD: begin
        if (gx == gy) begin
          g    <= gx << shift;
          bitc <= 6'(MW - 1);
          rem  <= '0;
          q    <= '0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1; gy <= gy >> 1; shift <= shift + 7'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx > gy) begin
          gx <= (gx - gy) >> 1;
        end else begin
          gy <= (gy - gx) >> 1;
        end
      end
      rau_pkg::BK_DIVN, rau_pkg::BK_DIVD: begin
        if (bitc == '0) begin
          if (state == rau_pkg::BK_DIVN) begin
            nm   <= {q[MW-2:0], !trial[MW]};
            rem  <= '0;
            q    <= '0;
            bitc <= 6'(MW - 1);
          end else begin
            dm <= {q[MW-2:0], !trial[MW]};
          end
        end else begin
          if (!trial[MW]) begin
            rem <= trial[MW-1:0];
            q   <= {q[MW-2:0], 1'b1};
          end else begin
            rem <= {rem[MW-2:0], dividend[bitc]};
            q   <= {q[MW-2:0], 1'b0};
          end
          bitc <= bitc - 6'd1;
        end
      end
      rau_pkg::BK_CHECK: begin
        result_numerator   <= '0;
        result_denominator <= '0;
        if (dm == '0) begin
          status <= rau_pkg::ST_ZERO_DEN;
        end else if (dm > Half - 1 || (neg ? nm > Half : nm > Half - 1)) begin
          status <= rau_pkg::ST_OVERFLOW;
        end else begin
          status             <= rau_pkg::ST_OK;
          result_numerator   <= neg ? (~nm[31:0] + 32'd1) : nm[31:0];
          result_denominator <= dm[30:0];
        end
      end
      default: ;
    endcase
  end

  assign job_ready = (state == rau_pkg::BK_IDLE);
  assign valid     = (state == rau_pkg::BK_OUT);

  property p_ok_den_nonzero;
    @(posedge clk) disable iff (rst)
      (valid && status == rau_pkg::ST_OK) |-> (result_denominator != '0);
  endproperty
  assert property (p_ok_den_nonzero) else $error("ok result with zero denominator");

  property p_err_zero_out;
    @(posedge clk) disable iff (rst)
      (valid && status != rau_pkg::ST_OK) |-> (result_numerator == '0 && result_denominator == '0);
  endproperty
  assert property (p_err_zero_out) else $error("error result with nonzero fields");

  property p_out_hold;
    @(posedge clk) disable iff (rst) (valid && !ready) |=> valid && $stable(status);
  endproperty
  assert property (p_out_hold) else $error("result dropped while stalled");

endmodule

// ===== hw/rtl/rational_arith_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_top: fraction add/sub/mul/div with gcd reduction
// Front end forms cross products, a two-entry queue, back end reduces.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | operation, a_/b_ numerator, denominator
// out     | out_valid/out_ready| result_numerator, result_denominator, status
//
// Front end: one shared multiplier; add and sub use three products, mul and div two.
// Back end: on a zero part straight to the range check and output; otherwise
// binary gcd, then two 64-bit restoring divisions by the gcd, one job at a
// time; this loop sets the rate.
// Reset clears all control state; no clearing pass.
// Either side may stall; the queue lets the front end run ahead.
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  a_numerator,
  input  logic signed [31:0]  a_denominator,
  input  logic signed [31:0]  b_numerator,
  input  logic signed [31:0]  b_denominator,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  result_numerator,
  output logic [30:0]         result_denominator,
  output logic [1:0]          status
);

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  rau_pkg::job_t fq_job, qb_job;

  rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst,
    .valid(in_valid), .ready(in_ready),
    .operation, .a_numerator, .a_denominator, .b_numerator, .b_denominator,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  rau_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
  );

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .valid(out_valid), .ready(out_ready),
    .result_numerator, .result_denominator, .status
  );

endmodule
